[rtl/core/tmsf_pkg.sv]
package tmsf_pkg;

   localparam int WINDOW_SIZE   = 16;
   localparam int TRIM_EACH_END = 2;

   localparam int SAMPLE_W = 12;
   localparam int TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

   // window index and rank width, and a width that can hold the window size itself
   localparam int IDX_W = $clog2(WINDOW_SIZE);
   localparam int CNT_W = IDX_W + 1;

   // ranks kept after trimming: TRIM_EACH_END <= rank < KEEP_HI
   localparam int KEEP_HI = (2 * TRIM_EACH_END < WINDOW_SIZE) ?
                            WINDOW_SIZE - TRIM_EACH_END : TRIM_EACH_END;
   localparam int KEPT    = KEEP_HI - TRIM_EACH_END;

   localparam int SUM_W   = SAMPLE_W + IDX_W;
   localparam int MAX_SUM = KEPT * ((1 << SAMPLE_W) - 1);

   // scaled reciprocal of the kept count, exact floor for every sum below 2**SUM_W
   localparam int KEPT_DIV    = (KEPT == 0) ? 1 : KEPT;
   localparam int RECIP_SHIFT = SUM_W + $clog2(KEPT_DIV);
   localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + KEPT_DIV - 1) / KEPT_DIV;
   localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

   typedef enum logic [2:0] {
      ST_FILL,
      ST_KEY,
      ST_SCAN,
      ST_ACC,
      ST_DIV,
      ST_PUT
   } fsm_type;

   typedef struct packed {
      logic clear;
      logic load_key;
      logic step;
   } rank_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/core/tmsf_ram.sv]
module tmsf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tmsf_rank_unit.sv]
module tmsf_rank_unit
   import tmsf_pkg::*;
(
   input  logic                clock,
   input  rank_ctl_type        ctl,
   input  logic [SAMPLE_W-1:0] data,
   input  logic [IDX_W-1:0]    data_idx,
   input  logic [IDX_W-1:0]    key_idx,
   output logic [SAMPLE_W-1:0] key,
   output logic                kept
);

   logic [SAMPLE_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]    rank_ff, rank_in;
   logic                less;

   // ties broken by position so every entry gets a distinct rank
   assign less = (data < key_ff) || ((data == key_ff) && (data_idx < key_idx));

   always_comb begin
      key_in  = key_ff;
      rank_in = rank_ff;
      if (ctl.load_key) begin
         key_in = data;
      end
      if (ctl.clear) begin
         rank_in = '0;
      end else if (ctl.step) begin
         rank_in = rank_ff + IDX_W'(less);
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      rank_ff <= rank_in;
   end

   assign key  = key_ff;
   assign kept = ({1'b0, rank_ff} >= CNT_W'(TRIM_EACH_END)) &&
                 ({1'b0, rank_ff} <  CNT_W'(KEEP_HI));

endmodule

[rtl/core/tmsf_divider.sv]
module tmsf_divider
   import tmsf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    dividend,
   output div_status_type      status,
   output logic [SAMPLE_W-1:0] quotient
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // floor division by the kept count as a multiply by its scaled reciprocal
   always_comb begin
      prod_in = prod_ff;
      busy_in = start;
      done_in = busy_ff;
      if (start) begin
         prod_in = PROD_W'(dividend) * PROD_W'(RECIP_MUL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = prod_ff[RECIP_SHIFT +: SAMPLE_W];

endmodule

[rtl/core/trimmed_mean_sample_filter_unit.sv]
// trimmed mean filter for raw 12-bit adc samples
// req channel: one sample per request in req_tdata[11:0]; samples collect in
// windows of 16 held in a small ram.  no result for the first 15 of a window.
// the 16th request starts evaluation: each stored sample is ranked against all
// others by one shared comparator (16 ram reads per sample), samples of rank
// 2..13 are summed, then a multiply by the scaled reciprocal of 12 forms the
// floor mean.  req_tready is low throughout, from the 16th request to
// rsp_tvalid, so no sample of the next window is taken while a window is
// being evaluated.
// rsp channel: the mean in rsp_tdata[11:0] sits in an output register; if the
// receiver stalls, the block takes new samples for the next window meanwhile
// and only waits at the end of that window's evaluation until the register
// is free.
// reset (synchronous, active high) empties the window and drops any pending
// result; the sample ram itself is not cleared.
module trimmed_mean_sample_filter_unit
   import tmsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [11:0] sample
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata    // [11:0] mean_raw
);

   fsm_type             state_ff, state_in;
   logic [IDX_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    key_idx_ff, key_idx_in;
   logic [IDX_W-1:0]    pend_ff, pend_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                wr_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   rank_ctl_type        rank_ctl;
   logic [SAMPLE_W-1:0] key;
   logic                kept;
   logic                div_start;
   div_status_type      div_status;
   logic [SAMPLE_W-1:0] quotient;
   logic [SAMPLE_W-1:0] mean;

   assign req_fire = req_tvalid && req_tready;
   assign mean     = (KEPT == 0) ? '0 : quotient;

   tmsf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_tdata[SAMPLE_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tmsf_rank_unit u_rank (
      .clock    (clock),
      .ctl      (rank_ctl),
      .data     (rd_data),
      .data_idx (pend_ff),
      .key_idx  (key_idx_ff),
      .key      (key),
      .kept     (kept)
   );

   // the last sample's contribution joins the sum in the start cycle
   tmsf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .status   (div_status),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_idx_ff  <= key_idx_in;
      pend_ff     <= pend_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      key_idx_in   = key_idx_ff;
      pend_in      = pend_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = '0;
      rank_ctl     = '0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_FILL: begin
            req_tready = 1'b1;
            if (req_fire) begin
               wr_en = 1'b1;
               if (fill_ff == LAST_IDX) begin
                  fill_in    = '0;
                  key_idx_in = '0;
                  sum_in     = '0;
                  state_in   = ST_KEY;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_KEY: begin
            // sample under test arrives now, first scan read goes out
            rank_ctl.load_key = 1'b1;
            rank_ctl.clear    = 1'b1;
            pend_in           = '0;
            state_in          = ST_SCAN;
         end
         ST_SCAN: begin
            rank_ctl.step = 1'b1;
            if (pend_ff == LAST_IDX) begin
               state_in = ST_ACC;
            end else begin
               rd_addr = pend_ff + 1'b1;
               pend_in = pend_ff + 1'b1;
            end
         end
         ST_ACC: begin
            if (kept) begin
               sum_in = sum_ff + SUM_W'(key);
            end
            if (key_idx_ff == LAST_IDX) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               rd_addr    = key_idx_ff + 1'b1;
               key_idx_in = key_idx_ff + 1'b1;
               state_in   = ST_KEY;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mean;
               state_in     = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   // a write request always advances the fill position by one, wrapping at the window end
   a_fill_advance: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (fill_ff == $past(fill_ff) + 1'b1) || (fill_ff == '0 && state_ff == ST_KEY))
      else $error("fill position did not advance on a request");

   // the divider is only started when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   // a new result only appears after the put step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_PUT)
      else $error("result appeared outside the put step");

   // the trimmed sum can never exceed kept samples at full scale
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> sum_ff <= SUM_W'(MAX_SUM))
      else $error("trimmed sum out of range");

endmodule

[sim/tb_trimmed_mean_sample_filter_unit.sv]
module tb_trimmed_mean_sample_filter_unit
   import tmsf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_WINDOWS    = 27;
   localparam int CALM_WINDOWS   = 5;
   localparam int LONG_HOLD      = 1200;
   localparam int DRAIN_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum int {
      MIX_UNIFORM,
      MIX_CONSTANT,
      MIX_EXTREMES,
      MIX_NARROW,
      MIX_RISING,
      MIX_FALLING,
      MIX_OUTLIERS,
      MIX_COUNT
   } window_mix_type;

   // software copy of the window, sorting and trimming done per full window
   class trimmed_mean_tracker;
      logic [SAMPLE_W-1:0] window_buf [WINDOW_SIZE];
      int                  fill_level;
      logic [SAMPLE_W-1:0] pending_means [$];
      int                  samples_seen;
      int                  means_checked;
      int                  mismatches;

      function new();
         fill_level    = 0;
         samples_seen  = 0;
         means_checked = 0;
         mismatches    = 0;
      endfunction

      function logic [SAMPLE_W-1:0] trimmed_mean();
         logic [SAMPLE_W-1:0] sorted [WINDOW_SIZE];
         logic [SAMPLE_W-1:0] key;
         int                  j;
         int                  lo;
         int                  hi;
         int                  total;
         lo = TRIM_EACH_END;
         hi = (2 * TRIM_EACH_END < WINDOW_SIZE) ? WINDOW_SIZE - TRIM_EACH_END : lo;
         for (int i = 0; i < WINDOW_SIZE; i++) sorted[i] = window_buf[i];
         for (int i = 1; i < WINDOW_SIZE; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = key;
         end
         total = 0;
         for (int i = lo; i < hi; i++) total += sorted[i];
         // nothing left between the trimmed ends gives zero
         if (hi <= lo) return '0;
         return SAMPLE_W'(total / (hi - lo));
      endfunction

      function void add_sample(logic [TDATA_W-1:0] word);
         // bits above the sample are ignored by the block
         window_buf[fill_level] = word[SAMPLE_W-1:0];
         fill_level++;
         samples_seen++;
         if (fill_level == WINDOW_SIZE) begin
            fill_level = 0;
            pending_means.push_back(trimmed_mean());
         end
      endfunction

      function void check_mean(logic [TDATA_W-1:0] word);
         logic [SAMPLE_W-1:0] want;
         if (pending_means.size() == 0) begin
            $error("unexpected result: mean_raw %0d", word[SAMPLE_W-1:0]);
            mismatches++;
            return;
         end
         want = pending_means.pop_front();
         means_checked++;
         if (word[SAMPLE_W-1:0] !== want) begin
            $error("mean_raw: expected %0d, actual %0d", want, word[SAMPLE_W-1:0]);
            mismatches++;
         end
         if (word[TDATA_W-1:SAMPLE_W] !== '0) begin
            $error("rsp_tdata padding: expected 0, actual %0h", word[TDATA_W-1:SAMPLE_W]);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;   // [11:0] sample
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;         // [11:0] mean_raw

   trimmed_mean_tracker tracker = new();
   bit                  idle_on   = 1'b1;
   bit                  long_hold = 1'b0;
   int                  windows_sent;

   trimmed_mean_sample_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitors both channels and keeps the stall watchdog
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (req_tvalid && req_tready) tracker.add_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_mean(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: short random stalls, and one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold) begin
            long_hold  = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      logic [TDATA_W-1:0] word;
      word = TDATA_W'($urandom);
      word[SAMPLE_W-1:0] = value;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_window(input window_mix_type mix, input int count);
      int base;
      int level;
      base = $urandom_range(0, (1 << SAMPLE_W) - 1);
      for (int i = 0; i < count; i++) begin
         case (mix)
            MIX_CONSTANT: level = base;
            MIX_EXTREMES: level = $urandom_range(0, 1) ? (1 << SAMPLE_W) - 1 : 0;
            MIX_NARROW:   level = base + $urandom_range(0, 15);
            MIX_RISING:   level = i * 255 + $urandom_range(0, 15);
            MIX_FALLING:  level = (WINDOW_SIZE - 1 - i) * 255 + $urandom_range(0, 15);
            MIX_OUTLIERS: begin
               if ($urandom_range(0, 4) == 0)
                  level = $urandom_range(0, 1) ? (1 << SAMPLE_W) - 1 : 0;
               else
                  level = base + $urandom_range(0, 31) - 16;
            end
            default:      level = $urandom_range(0, (1 << SAMPLE_W) - 1);
         endcase
         if (level < 0) level = 0;
         if (level > (1 << SAMPLE_W) - 1) level = (1 << SAMPLE_W) - 1;
         send_sample(SAMPLE_W'(level));
      end
      windows_sent++;
   endtask

   initial begin
      window_mix_type mix;
      windows_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // alternating floor and full-scale samples, junk in the unused bits
      for (int i = 0; i < WINDOW_SIZE; i++)
         send_sample((i % 2) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}});
      windows_sent++;

      for (int w = 0; w < NUM_WINDOWS; w++) begin
         if (w == NUM_WINDOWS - CALM_WINDOWS) idle_on = 1'b0;
         // receiver holds off so the next window fills and the input backs up
         if (w == 10) long_hold = 1'b1;
         mix = window_mix_type'($urandom_range(0, MIX_COUNT - 1));
         send_window(mix, WINDOW_SIZE);
         if (w == 20) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (tracker.pending_means.size() != 0) @(posedge clock);
         end
      end

      // trailing partial window, never completes
      send_window(MIX_UNIFORM, $urandom_range(1, WINDOW_SIZE - 1));
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (tracker.pending_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.pending_means.size() != 0) begin
         $error("%0d results never arrived", tracker.pending_means.size());
         tracker.mismatches++;
      end
      $display("%0d samples in %0d windows (plus a partial one), %0d means checked",
               tracker.samples_seen, windows_sent - 1, tracker.means_checked);
      $display("mixes: uniform, constant, extremes, narrow, ramps, outliers; long rsp hold-off");
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
